// ===== sv/rac_pkg.sv =====
// Shared types and constants for the roll attitude controller.
package rac_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned DRIVE_W = 18;
	localparam int unsigned PROD_W  = 32;

	// Derivative filter pole and leak, both Q16
	localparam logic [WORD_W-1:0] FILT_POLE = 16'd59297;
	localparam logic [WORD_W-1:0] FILT_LEAK = 16'd6239;

	typedef enum logic [2:0] {
		CFG_ROLL_PROP_GAIN   = 3'd0,
		CFG_YAW_DAMP_GAIN    = 3'd1,
		CFG_ROLL_RATE_GAIN   = 3'd2,
		CFG_ACCEL_FILT_GAIN  = 3'd3,
		CFG_HOVER_DAMP_GAIN  = 3'd4,
		CFG_HOVER_NAV_RADIUS = 3'd5,
		CFG_ENABLE_BITS      = 3'd6
	} cfg_idx_t;

	localparam int unsigned EN_NAV  = 0;
	localparam int unsigned EN_ROLL = 1;
	localparam int unsigned EN_YAW  = 2;

	typedef enum logic [2:0] {
		MS_FIRST,
		MS_YAW,
		MS_ACCEL,
		MS_POLE,
		MS_LEAK,
		MS_RATE
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_FIRST,
		ST_MUL_YAW,
		ST_MUL_ACCEL,
		ST_MUL_POLE,
		ST_FILT,
		ST_MUL_LEAK,
		ST_MUL_RATE,
		ST_DONE_NORM,
		ST_DONE_HOVER
	} state_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_sub;
		logic     outer_ld;
		logic     a_ld;
		logic     filt_ld;
		logic     a_sub;
		logic     out_ld;
		logic     out_hover;
	} dp_cmd_t;

	typedef struct packed {
		logic hover;
	} dp_status_t;

endpackage

// ===== sv/rac_ctrl.sv =====
// Sequencer for the roll attitude controller: steps the shared multiplier and owns the beat flags.
module rac_ctrl import rac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.mul_sel = MS_FIRST;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_FIRST;
				end
			end
			ST_MUL_FIRST: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_FIRST;
				state_d     = status.hover ? ST_DONE_HOVER : ST_MUL_YAW;
			end
			ST_MUL_YAW: begin
				cmd.acc_sub = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_YAW;
				state_d     = ST_MUL_ACCEL;
			end
			ST_MUL_ACCEL: begin
				cmd.outer_ld = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MS_ACCEL;
				state_d      = ST_MUL_POLE;
			end
			ST_MUL_POLE: begin
				cmd.a_ld    = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_POLE;
				state_d     = ST_FILT;
			end
			ST_FILT: begin
				cmd.filt_ld = 1'b1;
				state_d     = ST_MUL_LEAK;
			end
			ST_MUL_LEAK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_LEAK;
				state_d     = ST_MUL_RATE;
			end
			ST_MUL_RATE: begin
				cmd.a_sub   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_RATE;
				state_d     = ST_DONE_NORM;
			end
			ST_DONE_NORM: begin
				// hold until the output slot frees up
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_DONE_HOVER: begin
				if (out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.out_hover = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/rac_dp.sv =====
// Datapath for the roll attitude controller: gain registers, shared multiplier, accumulators, filter state.
module rac_dp import rac_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [WORD_W-1:0]   cfg_data,
	input  logic [3:0]          in_flags,
	input  logic [6*WORD_W-1:0] in_words,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output logic [DRIVE_W-1:0]  roll_drive
);

	// gains
	logic [WORD_W-1:0] kp_q, kyaw_q, krate_q, kacc_q, khover_q;
	logic [14:0]       radius_q;
	logic [2:0]        enable_q;

	// captured tick
	logic                     hover_q, inv_q, gps_q, fb_q;
	logic signed [WORD_W-1:0] nav_q, tilt_q, yaw_q, rroll_q, rerr_q, fin_q;

	logic signed [WORD_W-1:0] filt_q;
	logic [PROD_W-1:0]        prod_q, acc_q, a_q;
	logic signed [WORD_W:0]   outer_q;
	logic [DRIVE_W-1:0]       drive_q;

	logic nav_en, roll_en, yaw_en;
	assign nav_en  = enable_q[EN_NAV] && gps_q;
	assign roll_en = enable_q[EN_ROLL] && fb_q;
	assign yaw_en  = enable_q[EN_YAW] && fb_q;

	assign status.hover = hover_q;
	assign roll_drive   = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= '0;
			kyaw_q   <= '0;
			krate_q  <= '0;
			kacc_q   <= '0;
			khover_q <= '0;
			radius_q <= '0;
			enable_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROLL_PROP_GAIN:   kp_q     <= cfg_data;
				CFG_YAW_DAMP_GAIN:    kyaw_q   <= cfg_data;
				CFG_ROLL_RATE_GAIN:   krate_q  <= cfg_data;
				CFG_ACCEL_FILT_GAIN:  kacc_q   <= cfg_data;
				CFG_HOVER_DAMP_GAIN:  khover_q <= cfg_data;
				CFG_HOVER_NAV_RADIUS: radius_q <= cfg_data[14:0];
				CFG_ENABLE_BITS:      enable_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// shared signed-by-unsigned multiplier
	logic signed [WORD_W-1:0] mul_s;
	logic [WORD_W-1:0]        mul_u;
	logic signed [PROD_W:0]   mul_full;

	always_comb begin
		case (cmd.mul_sel)
			MS_FIRST: begin
				mul_s = hover_q ? rroll_q : tilt_q;
				mul_u = hover_q ? khover_q : kp_q;
			end
			MS_YAW: begin
				mul_s = inv_q ? -yaw_q : yaw_q;
				mul_u = kyaw_q;
			end
			MS_ACCEL: begin
				mul_s = rerr_q;
				mul_u = kacc_q;
			end
			MS_POLE: begin
				mul_s = filt_q;
				mul_u = FILT_POLE;
			end
			MS_LEAK: begin
				mul_s = filt_q;
				mul_u = FILT_LEAK;
			end
			MS_RATE: begin
				mul_s = rerr_q;
				mul_u = krate_q;
			end
			default: begin
				mul_s = rerr_q;
				mul_u = krate_q;
			end
		endcase
	end

	assign mul_full = (PROD_W+1)'(mul_s) * (PROD_W+1)'($signed({1'b0, mul_u}));

	// yaw damping enters through the high word of the negated product
	logic [PROD_W-1:0]        yaw_neg;
	logic signed [WORD_W-1:0] yawfb;
	logic [PROD_W-1:0]        filt_sum;
	logic signed [DRIVE_W:0]  norm_sum;
	logic signed [DRIVE_W:0]  hover_sum;
	logic signed [WORD_W-1:0] navd, damp;

	assign yaw_neg  = PROD_W'(0) - prod_q;
	assign yawfb    = yaw_en ? $signed(yaw_neg[PROD_W-1:WORD_W]) : '0;
	assign filt_sum = prod_q + a_q;

	always_comb begin
		norm_sum = (DRIVE_W+1)'(outer_q);
		if (roll_en) begin
			norm_sum = norm_sum + (DRIVE_W+1)'($signed(a_q[PROD_W-1:WORD_W]))
				+ (DRIVE_W+1)'($signed(prod_q[PROD_W-1:WORD_W]));
		end
		navd = '0;
		damp = '0;
		if (fb_q) begin
			if (nav_en && ($signed({fin_q[WORD_W-1], fin_q}) > $signed({2'b00, radius_q}))) begin
				navd = nav_q;
			end
			damp = $signed(prod_q[PROD_W-1:WORD_W]);
		end
		hover_sum = (DRIVE_W+1)'(navd) - (DRIVE_W+1)'(damp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (cmd.filt_ld && roll_en) begin
			filt_q <= $signed(filt_sum[PROD_W-1:WORD_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			{fb_q, gps_q, inv_q, hover_q} <= in_flags;
			nav_q   <= $signed(in_words[0*WORD_W +: WORD_W]);
			tilt_q  <= $signed(in_words[1*WORD_W +: WORD_W]);
			yaw_q   <= $signed(in_words[2*WORD_W +: WORD_W]);
			rroll_q <= $signed(in_words[3*WORD_W +: WORD_W]);
			rerr_q  <= $signed(in_words[4*WORD_W +: WORD_W]);
			fin_q   <= $signed(in_words[5*WORD_W +: WORD_W]);
			acc_q   <= (enable_q[EN_NAV] && in_flags[2])
				? {in_words[0*WORD_W +: WORD_W], {WORD_W{1'b0}}} : '0;
		end else if (cmd.acc_sub && roll_en) begin
			acc_q <= acc_q - prod_q;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_full[PROD_W-1:0];
		end
		if (cmd.outer_ld) begin
			outer_q <= (WORD_W+1)'($signed(acc_q[PROD_W-1:WORD_W])) - (WORD_W+1)'(yawfb);
		end
		if (cmd.a_ld) begin
			a_q <= prod_q;
		end else if (cmd.a_sub) begin
			a_q <= a_q - prod_q;
		end
		if (cmd.out_ld) begin
			drive_q <= cmd.out_hover ? hover_sum[DRIVE_W-1:0] : norm_sum[DRIVE_W-1:0];
		end
	end

endmodule

// ===== sv/roll_attitude_controller.sv =====
// Top level of the roll attitude controller: stream ports, config port, sequencer and datapath.
//
// One input beat is one control tick and yields one roll drive beat. A normal-mode tick
// runs from the accepting idle state through the six multiply states, with the filter
// update state between the pole and leak products, to the done state that loads the output
// register; a hover-mode tick runs from its first product straight to its done state. The
// sequencer steps the single 16x16 multiplier through these products one per cycle, and a
// new tick is taken only once the previous one has been loaded. A result still waiting
// in the output register holds the next result back for as long as the downstream side
// stalls. The output register lets a finished result wait for the downstream side while the
// next tick is taken. Gain registers are written through the config port, which is always
// ready; write them only while idle.
module roll_attitude_controller import rac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// nav_deflection, tilt_error, yaw_rate, roll_rate, rate_error, finish_distance
	input  logic [95:0] s_tdata,
	// hover_mode, inverted, nav_steer, stab_feedback
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// roll_drive (18 bits), zero filled
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic [DRIVE_W-1:0] roll_drive;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {{(24-DRIVE_W){1'b0}}, roll_drive};

	rac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rac_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_flags   (s_tuser),
		.in_words   (s_tdata),
		.cmd        (cmd),
		.status     (status),
		.roll_drive (roll_drive)
	);

endmodule
